// ----- rtl/fpa_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: opcodes, widths and helper types.
// No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int DataWidth = 32;
   localparam int FracBitsDefault = 8;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_EQ = 4'd4, OP_NE = 4'd5, OP_LT = 4'd6, OP_LE = 4'd7,
      OP_GT = 4'd8, OP_GE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
   } op_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 flag;
      logic                 div_zero;
   } res_type;
endpackage

// ----- rtl/fixed_point_alu_q24_8_core.sv -----
// Q24.8 fixed-point ALU top level: pipeline control, multiplier and result select.
// Depends on fpa_pkg and fpa_div.
//
// Usage: drive req_tdata {b_raw, a_raw} with req_tuser = func; one transaction
// on the req side gives exactly one on the rsp side, in order.
// rsp_tdata = result, rsp_tuser = {div_zero, flag}.
// The divider resolves one quotient bit per pipeline stage; the merged result
// then passes through the output register.
// Throughput: one transaction per cycle; every operation takes the same path.
// The whole pipeline advances when the output register is empty or taken;
// a stall on rsp_tready freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// The block holds no state between transactions and has no configuration.
//
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_core import fpa_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] a_raw, [63:32] b_raw
   input  logic [3:0]  req_tuser,   // [3:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result
   output logic [1:0]  rsp_tuser    // [0] flag, [1] div_zero
);
   localparam int NW = DataWidth + FRAC_BITS;
   localparam int Depth = NW + 1;

   logic advance;
   logic [Depth-1:0] vld_ff;
   assign advance    = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end

   // stage 1: decode, compares, simple ops, divider operand magnitudes
   op_type op_in;
   logic signed [DataWidth-1:0] a_in, b_in;
   assign op_in = op_type'(req_tuser);
   assign a_in  = req_tdata[31:0];
   assign b_in  = req_tdata[63:32];

   logic lt_in, eq_in;
   assign lt_in = a_in < b_in;
   assign eq_in = a_in == b_in;

   res_type s1_in;
   always_comb begin
      s1_in = '0;
      unique case (op_in)
         OP_ADD:      s1_in.result = a_in + b_in;
         OP_SUB:      s1_in.result = a_in - b_in;
         OP_MUL:      s1_in.result = '0;
         OP_DIV:      s1_in.div_zero = (b_in == '0);
         OP_EQ:       s1_in.flag = eq_in;
         OP_NE:       s1_in.flag = !eq_in;
         OP_LT:       s1_in.flag = lt_in;
         OP_LE:       s1_in.flag = lt_in || eq_in;
         OP_GT:       s1_in.flag = !(lt_in || eq_in);
         OP_GE:       s1_in.flag = !lt_in;
         OP_MIN:      s1_in.result = lt_in ? a_in : b_in;
         OP_MAX:      s1_in.result = (!lt_in && !eq_in) ? a_in : b_in;
         OP_INC:      s1_in.result = a_in + 32'sd1;
         OP_DEC:      s1_in.result = a_in - 32'sd1;
         OP_FROM_INT: s1_in.result = a_in <<< FRAC_BITS;
         OP_TO_INT:   s1_in.result = a_in >>> FRAC_BITS;
         default:     s1_in = '0;
      endcase
   end

   logic [DataWidth-1:0] amag_in, bmag_in;
   assign amag_in = a_in[DataWidth-1] ? (~a_in + 1'b1) : a_in;
   assign bmag_in = b_in[DataWidth-1] ? (~b_in + 1'b1) : b_in;

   logic [NW-1:0] num_in;
   assign num_in = {amag_in, {FRAC_BITS{1'b0}}};

   // tag: {is_mul, is_div, quotient negative, divisor zero}
   localparam int TW = 4;
   logic [TW-1:0] tag_in;
   assign tag_in = {op_in == OP_MUL, op_in == OP_DIV,
                    a_in[DataWidth-1] ^ b_in[DataWidth-1], b_in == '0};

   // keep the simple result and the multiply product aligned with the divider
   res_type s1_ff [Depth-1];
   logic signed [2*DataWidth-1:0] prod_ff;
   logic signed [DataWidth-1:0] ma_ff, mb_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff[0] <= s1_in;
         ma_ff    <= a_in;
         mb_ff    <= b_in;
         prod_ff  <= ma_ff * mb_ff;
         for (int i = 1; i < Depth - 1; i++) begin
            s1_ff[i] <= s1_ff[i-1];
         end
      end
   end

   // product line: the product is ready at stage 2, delay it to the end
   logic [DataWidth-1:0] mres_ff [Depth-3];
   always_ff @(posedge clock) begin
      if (advance) begin
         mres_ff[0] <= prod_ff[FRAC_BITS +: DataWidth];
         for (int i = 1; i < Depth - 3; i++) begin
            mres_ff[i] <= mres_ff[i-1];
         end
      end
   end

   logic [NW-1:0] quo;
   logic [TW-1:0] tag_o;
   fpa_div #(.NW(NW), .DW(DataWidth), .TW(TW)) u_div (
      .clock  (clock),
      .advance(advance),
      .num    (num_in),
      .den    (bmag_in),
      .tag_i  (tag_in),
      .quo    (quo),
      .tag_o  (tag_o)
   );

   // final stage: sign fix of the quotient and merge
   logic [DataWidth-1:0] q_lo;
   assign q_lo = quo[DataWidth-1:0];

   res_type out_in, out_ff;
   always_comb begin
      out_in = s1_ff[Depth-2];
      priority if (tag_o[3]) begin
         out_in.result = mres_ff[Depth-4];
      end else if (tag_o[2] && !tag_o[0]) begin
         out_in.result = tag_o[1] ? (~q_lo + 1'b1) : q_lo;
      end else begin
         out_in.result = out_in.result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = vld_ff[Depth-1];
   assign rsp_tdata  = out_ff.result;
   assign rsp_tuser  = {out_ff.div_zero, out_ff.flag};

`ifndef SYNTH
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("flag and div_zero both set");
   a_dz_res: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("zero divisor gave nonzero result");
`endif
endmodule

// ----- rtl/fpa_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_div import fpa_pkg::*; #(
   parameter int NW = 40,
   parameter int DW = 32,
   parameter int TW = 4
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag_i,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_o
);
   // per stage: partial remainder, remaining dividend/quotient bits, divisor
   logic [DW:0]   rem_ff [NW+1];
   logic [NW-1:0] nq_ff  [NW+1];
   logic [DW-1:0] den_ff [NW+1];
   logic [TW-1:0] tag_ff [NW+1];

   always_comb begin
      rem_ff[0] = '0;
      nq_ff[0]  = num;
      den_ff[0] = den;
      tag_ff[0] = tag_i;
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW:0]   trial_in;
      logic [DW+1:0] diff_in;
      assign trial_in = {rem_ff[s][DW-1:0], nq_ff[s][NW-1]};
      assign diff_in  = {1'b0, trial_in} - {2'b00, den_ff[s]};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!diff_in[DW+1]) begin
               rem_ff[s+1] <= diff_in[DW:0];
            end else begin
               rem_ff[s+1] <= trial_in;
            end
            nq_ff[s+1]  <= {nq_ff[s][NW-2:0], ~diff_in[DW+1]};
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign quo   = nq_ff[NW];
   assign tag_o = tag_ff[NW];
endmodule
